// ===== hw/rtl/rlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants for the run-length pixel expander.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  localparam int RUN_W       = 16;
  localparam int LEN_W       = 7;
  localparam int CNT_W       = 7;
  localparam int COLOR_W     = 8;
  localparam int POS_W       = 16;
  localparam int ROW_W       = 8;
  localparam int X_W         = 9;
  localparam int MAX_RESULTS = 64;
  localparam int COLOR_BIT   = 7;

  // register select, taken from paddr[2]
  localparam logic REG_LIT  = 1'b0;
  localparam logic REG_DARK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_END
  } seq_state_t;

  typedef struct packed {
    logic step;
    logic frame_end;
  } pos_ctrl_t;

endpackage

// ===== hw/rtl/rlpe_pos.sv =====
// ----------------------------------------------------------------------------
// rlpe_pos
// Position stepper: linear offset, column, row and frame counter.
// ----------------------------------------------------------------------------
module rlpe_pos
  import rlpe_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_PIXELS = 64000,
  parameter int XW           = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  pos_ctrl_t        ctrl,
  output logic [POS_W-1:0] pos,
  output logic [XW-1:0]    col,
  output logic [ROW_W-1:0] row,
  output logic [POS_W-1:0] frame
);

  localparam logic [XW-1:0]    COL_LAST  = XW'(FRAME_WIDTH - 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_PIXELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      col   <= '0;
      row   <= '0;
      frame <= POS_W'(1);
    end else if (ctrl.step) begin
      pos <= pos + POS_W'(1);
      if (col == COL_LAST) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + XW'(1);
      end
    end else if (ctrl.frame_end && (pos > POS_LIMIT)) begin
      pos   <= '0;
      col   <= '0;
      row   <= '0;
      frame <= frame + POS_W'(1);
    end
  end

endmodule

// ===== hw/rtl/rlpe_seq.sv =====
// ----------------------------------------------------------------------------
// rlpe_seq
// Run sequencer: takes a run request, steps the position once per pixel and
// loads the pixel output register.
// ----------------------------------------------------------------------------
module rlpe_seq
  import rlpe_pkg::*;
#(
  parameter int FRAME_PIXELS = 64000,
  parameter int MAX_RUN      = 127,
  parameter int XW           = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RUN_W-1:0]   run_word,
  input  logic [COLOR_W-1:0] lit_color,
  input  logic [COLOR_W-1:0] dark_color,
  input  logic [POS_W-1:0]   pos,
  input  logic [XW-1:0]      col,
  input  logic [ROW_W-1:0]   row,
  input  logic [POS_W-1:0]   frame,
  output pos_ctrl_t          ctrl,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [X_W-1:0]     pixel_x,
  output logic [ROW_W-1:0]   pixel_y,
  output logic [POS_W-1:0]   pixel_offset,
  output logic [COLOR_W-1:0] pixel_color,
  output logic [POS_W-1:0]   frame_number,
  output logic               run_last
);

  localparam logic [POS_W-1:0] POS_END  = POS_W'(FRAME_PIXELS);
  localparam logic [POS_W-1:0] POS_TAIL = POS_W'(FRAME_PIXELS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);
  localparam logic [CNT_W-1:0] CNT_TAIL = CNT_W'(MAX_RESULTS - 1);
  localparam logic [LEN_W-1:0] RUN_CAP  = LEN_W'(MAX_RUN);

  seq_state_t         state, state_next;
  logic [LEN_W-1:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic [COLOR_W-1:0] color;
  logic [LEN_W-1:0]   len;
  logic               emit;
  logic               advance;
  logic               last_pix;

  assign len      = (run_word[LEN_W-1:0] > RUN_CAP) ? RUN_CAP : run_word[LEN_W-1:0];
  assign emit     = (pos < POS_END) && (cnt < CNT_MAX);
  assign advance  = (state == ST_RUN) && (!emit || !out_valid || !out_stall);
  assign last_pix = (rem == LEN_W'(1)) || (pos == POS_TAIL) || (cnt == CNT_TAIL);
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctrl.step      = 1'b0;
    ctrl.frame_end = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (len == '0) ? ST_END : ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          ctrl.step = 1'b1;
          if (rem == LEN_W'(1)) begin
            state_next = ST_END;
          end
        end
      end
      ST_END: begin
        ctrl.frame_end = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      cnt <= '0;
    end else if ((state == ST_IDLE) && in_valid) begin
      rem <= len;
      cnt <= '0;
    end else if (advance) begin
      rem <= rem - LEN_W'(1);
      if (emit) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      color <= run_word[COLOR_BIT] ? lit_color : dark_color;
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      pixel_x      <= X_W'(col);
      pixel_y      <= row;
      pixel_offset <= pos;
      pixel_color  <= color;
      frame_number <= frame;
      run_last     <= last_pix;
    end
  end

endmodule

// ===== hw/rtl/run_length_pixel_expander.sv =====
// ----------------------------------------------------------------------------
// run_length_pixel_expander
// Expands run words into pixel writes and tracks pixel position and frame.
// ----------------------------------------------------------------------------
// A run word is taken when the block is idle; bit 7 picks the lit or dark
// color and bits 6..0 the run length. The run is walked one pixel per cycle,
// except while the pixel output is stalled, by a single position stepper, so
// a request occupies the block while it takes the request, steps through each
// pixel of the run (including pixels past the frame end that are not written)
// and closes the run. A zero-length run goes from taking the request straight
// to closing the run. At most 64 pixel writes leave per run word.
module run_length_pixel_expander
  import rlpe_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_PIXELS = 64000,
  parameter int MAX_RUN      = 127
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RUN_W-1:0]   run_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [X_W-1:0]     pixel_x,
  output logic [ROW_W-1:0]   pixel_y,
  output logic [POS_W-1:0]   pixel_offset,
  output logic [COLOR_W-1:0] pixel_color,
  output logic [POS_W-1:0]   frame_number,
  output logic               run_last
);

  localparam int XW = $clog2(FRAME_WIDTH);

  logic [COLOR_W-1:0] lit_color;
  logic [COLOR_W-1:0] dark_color;
  logic               cfg_write;
  pos_ctrl_t          ctrl;
  logic [POS_W-1:0]   pos;
  logic [XW-1:0]      col;
  logic [ROW_W-1:0]   row;
  logic [POS_W-1:0]   frame;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_color  <= COLOR_W'(31);
      dark_color <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LIT:  lit_color  <= pwdata[COLOR_W-1:0];
        REG_DARK: dark_color <= pwdata[COLOR_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LIT:  prdata = {{(32-COLOR_W){1'b0}}, lit_color};
      REG_DARK: prdata = {{(32-COLOR_W){1'b0}}, dark_color};
      default:  prdata = '0;
    endcase
  end

  rlpe_pos #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_PIXELS (FRAME_PIXELS),
    .XW           (XW)
  ) u_pos (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .pos   (pos),
    .col   (col),
    .row   (row),
    .frame (frame)
  );

  rlpe_seq #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .MAX_RUN      (MAX_RUN),
    .XW           (XW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .run_word     (run_word),
    .lit_color    (lit_color),
    .dark_color   (dark_color),
    .pos          (pos),
    .col          (col),
    .row          (row),
    .frame        (frame),
    .ctrl         (ctrl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_offset (pixel_offset),
    .pixel_color  (pixel_color),
    .frame_number (frame_number),
    .run_last     (run_last)
  );

endmodule

// ===== hw/rtl/rlpe_checker.sv =====
// ----------------------------------------------------------------------------
// rlpe_checker
// Port-level checks for the run-length pixel expander.
// ----------------------------------------------------------------------------
module rlpe_checker
  import rlpe_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_PIXELS = 64000
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [X_W-1:0]   pixel_x,
  input logic [POS_W-1:0] pixel_offset,
  input logic             run_last
);

  // a taken request keeps the block busy
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pixel_offset) && $stable(run_last)))
    else $error("stalled pixel write changed");

  a_offset_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(pixel_offset) < FRAME_PIXELS))
    else $error("pixel write past frame end");

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(pixel_x) < FRAME_WIDTH))
    else $error("column out of range");

endmodule

bind run_length_pixel_expander rlpe_checker #(
  .FRAME_WIDTH  (FRAME_WIDTH),
  .FRAME_PIXELS (FRAME_PIXELS)
) u_rlpe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_x      (pixel_x),
  .pixel_offset (pixel_offset),
  .run_last     (run_last)
);
